@@ rtl/gf256_pkg.sv @@
// gf256_pkg: shared types, field constants and constant tables for the gf(2^8) unit
// field polynomial x^8+x^6+x^5+x^4+1, generator alpha = 0x02
// no dependencies
package gf256_pkg;

  // low byte of the field polynomial 0x171
  localparam logic [7:0] POLY_LOW = 8'h71;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_INV = 2'd1,
    OP_POW = 2'd2,
    OP_LOG = 2'd3
  } opcode_t;

  typedef logic [255:0][7:0] byte_tbl_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } op_req_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic       zero_operand;
  } op_res_t;

  // carryless product reduced modulo the field polynomial
  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = 8'h00;
    sh  = b;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) begin
        acc = acc ^ sh;
      end
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? POLY_LOW : 8'h00);
    end
    return acc;
  endfunction

  // alpha^e, with alpha^255 = 1
  function automatic byte_tbl_t gen_exp_tbl();
    byte_tbl_t  t;
    logic [7:0] v;
    t = '0;
    v = 8'h01;
    for (int e = 0; e < 255; e++) begin
      t[8'(e)] = v;
      v = gf_mul(v, 8'h02);
    end
    t[8'hFF] = 8'h01;
    return t;
  endfunction

  // discrete log, zero maps to zero
  function automatic byte_tbl_t gen_log_tbl();
    byte_tbl_t t;
    byte_tbl_t ex;
    t  = '0;
    ex = gen_exp_tbl();
    for (int e = 0; e < 255; e++) begin
      t[ex[8'(e)]] = 8'(e);
    end
    return t;
  endfunction

  // multiplicative inverse, zero maps to zero
  function automatic byte_tbl_t gen_inv_tbl();
    byte_tbl_t t;
    byte_tbl_t ex;
    byte_tbl_t lg;
    t  = '0;
    ex = gen_exp_tbl();
    lg = gen_log_tbl();
    for (int x = 1; x < 256; x++) begin
      t[8'(x)] = ex[8'hFF - lg[8'(x)]];
    end
    return t;
  endfunction

  localparam byte_tbl_t EXP_TBL = gen_exp_tbl();
  localparam byte_tbl_t LOG_TBL = gen_log_tbl();
  localparam byte_tbl_t INV_TBL = gen_inv_tbl();

endpackage

@@ rtl/gf256_in_if.sv @@
// gf256_in_if: request channel, valid/ready handshake with opcode and two operands
// depends on nothing
interface gf256_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] operand_a;
  logic [7:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input opcode, input operand_a, input operand_b,
                output ready);
endinterface

@@ rtl/gf256_out_if.sv @@
// gf256_out_if: result channel, valid/ready handshake with result byte and zero flag
// depends on nothing
interface gf256_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_value;
  logic       zero_operand;

  modport source (output valid, output result_value, output zero_operand, input ready);
  modport sink (input valid, input result_value, input zero_operand, output ready);
endinterface

@@ rtl/gf256_arithmetic_unit.sv @@
// gf256_arithmetic_unit: two-stage gf(2^8) arithmetic unit, one result per transaction
// a request is held in the request register, then in the result register
// throughput: one transaction per cycle without output stalls, set by stage registers
// reset: rst_n synchronous active low, clears both stage valid bits
// depends on gf256_pkg, gf256_in_if, gf256_out_if, gf256_alu
module gf256_arithmetic_unit (
  input  logic         clk,
  input  logic         rst_n,
  gf256_in_if.sink     in_ch,
  gf256_out_if.source  out_ch
);
  import gf256_pkg::*;

  // stage 1: captured request
  logic    req_v_r;
  op_req_t req_r;
  // stage 2: registered result
  logic    res_v_r;
  op_res_t res_r;

  op_res_t alu_res;
  logic    res_load;
  logic    req_load;

  // result stage takes a new value when empty or when its transaction leaves
  assign res_load = !res_v_r || out_ch.ready;
  // request stage takes a new transaction when empty or when it moves forward
  assign req_load = !req_v_r || res_load;

  assign in_ch.ready = req_load;

  gf256_alu u_alu (
    .req (req_r),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (req_load) begin
        req_v_r <= in_ch.valid;
      end
      if (res_load) begin
        res_v_r <= req_v_r;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (req_load && in_ch.valid) begin
      req_r.opcode    <= in_ch.opcode;
      req_r.operand_a <= in_ch.operand_a;
      req_r.operand_b <= in_ch.operand_b;
    end
    if (res_load && req_v_r) begin
      res_r <= alu_res;
    end
  end

  assign out_ch.valid        = res_v_r;
  assign out_ch.result_value = res_r.result_value;
  assign out_ch.zero_operand = res_r.zero_operand;

`ifndef SYNTHESIS
  // an accepted transaction always lands in the request stage
  a_req_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> req_v_r)
    else $error("accepted transaction not captured");

  // a pending request moves into the result stage whenever it has room
  a_req_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (req_v_r && res_load) |=> res_v_r)
    else $error("request lost between stages");

  // both stages full and output stalled: no new transaction may enter
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (req_v_r && res_v_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while pipeline full");

  // with nothing in flight and nothing accepted, no result appears
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!req_v_r && !res_v_r && !in_ch.valid) |=> !out_ch.valid)
    else $error("result without a transaction");
`endif

endmodule

@@ rtl/gf256_alu.sv @@
// gf256_alu: combinational gf(2^8) operation select (multiply, inverse, power, log)
// depends on gf256_pkg
module gf256_alu (
  input  gf256_pkg::op_req_t req,
  output gf256_pkg::op_res_t res
);
  import gf256_pkg::*;

  always_comb begin
    res.result_value = 8'h00;
    res.zero_operand = 1'b0;
    case (opcode_t'(req.opcode))
      OP_MUL: begin
        res.result_value = gf_mul(req.operand_a, req.operand_b);
      end
      OP_INV: begin
        res.result_value = INV_TBL[req.operand_a];
        res.zero_operand = (req.operand_a == 8'h00);
      end
      OP_POW: begin
        res.result_value = EXP_TBL[req.operand_a];
      end
      OP_LOG: begin
        res.result_value = LOG_TBL[req.operand_a];
        res.zero_operand = (req.operand_a == 8'h00);
      end
      default: begin
        res.result_value = 8'h00;
        res.zero_operand = 1'b0;
      end
    endcase
  end

endmodule

@@ tb/gf256_arithmetic_unit_test.sv @@
// gf256_arithmetic_unit_test: self-checking bench for the gf(2^8) arithmetic unit
// computes every expected result with its own field arithmetic and checks the result stream
// depends on gf256_pkg, gf256_in_if, gf256_out_if and gf256_arithmetic_unit
`timescale 1ns / 1ps

module gf256_arithmetic_unit_test;
  import gf256_pkg::*;

  // low byte of x^8+x^6+x^5+x^4+1, folded back in when x^8 appears
  localparam logic [7:0] FOLD_BYTE    = 8'h71;
  localparam int         RANDOM_ITEMS = 1300;
  localparam int         QUIET_TAIL   = 150;

  // one request waiting to be driven; hold makes the driver wait for an empty pipeline
  typedef struct {
    opcode_t    op;
    logic [7:0] a;
    logic [7:0] b;
    bit         hold;
  } field_req_t;

  // what the unit must answer for one accepted request
  typedef struct {
    opcode_t    op;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] value;
    logic       zflag;
  } field_res_t;

  logic clk = 1'b0;
  logic rst_n;

  gf256_in_if  in_ch ();
  gf256_out_if out_ch ();

  gf256_arithmetic_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  field_req_t pending_reqs[$];
  field_res_t awaited_results[$];
  field_req_t cur_req;

  int  total_reqs = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  mismatch_count = 0;
  int  zero_flag_count = 0;
  int  drain_waits = 0;
  int  op_seen[4] = '{0, 0, 0, 0};
  int  send_idle = 0;
  int  recv_stall = 0;
  bit  late_phase = 1'b0;

  // ---------------------------------------------------------------------------
  // field arithmetic used for the expected results
  // ---------------------------------------------------------------------------

  // multiply by alpha: shift left, reduce when bit 8 falls out
  function automatic logic [7:0] times_alpha(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? FOLD_BYTE : 8'h00);
  endfunction

  // shift-and-add product, the shifted operand kept reduced at every step
  function automatic logic [7:0] field_product(logic [7:0] x, logic [7:0] y);
    logic [7:0] acc;
    logic [7:0] sh;
    acc = 8'h00;
    sh  = y;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        acc ^= sh;
      end
      sh = times_alpha(sh);
    end
    return acc;
  endfunction

  // alpha^e by repeated stepping; alpha has order 255 so e = 255 lands on 1
  function automatic logic [7:0] alpha_power(int e);
    logic [7:0] v;
    v = 8'h01;
    for (int k = 0; k < e; k++) begin
      v = times_alpha(v);
    end
    return v;
  endfunction

  // walk the powers of alpha until x shows up; only called for nonzero x
  function automatic int discrete_log(logic [7:0] x);
    logic [7:0] v;
    v = 8'h01;
    for (int e = 0; e < 255; e++) begin
      if (v == x) begin
        return e;
      end
      v = times_alpha(v);
    end
    return 0;
  endfunction

  function automatic field_res_t predict_result(field_req_t r);
    field_res_t res;
    res.op    = r.op;
    res.a     = r.a;
    res.b     = r.b;
    res.value = 8'h00;
    res.zflag = 1'b0;
    case (r.op)
      OP_MUL: begin
        res.value = field_product(r.a, r.b);
      end
      OP_INV: begin
        // a^-1 = alpha^(255 - log a), wrapped so that 1 maps to 1
        if (r.a == 8'h00) begin
          res.zflag = 1'b1;
        end else begin
          res.value = alpha_power((255 - discrete_log(r.a)) % 255);
        end
      end
      OP_POW: begin
        res.value = alpha_power(int'(r.a));
      end
      default: begin
        if (r.a == 8'h00) begin
          res.zflag = 1'b1;
        end else begin
          res.value = 8'(discrete_log(r.a));
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_request(opcode_t op, logic [7:0] a, logic [7:0] b, bit hold);
    field_req_t r;
    r.op   = op;
    r.a    = a;
    r.b    = b;
    r.hold = hold;
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  // operands lean toward zero, one and all-ones, the rest uniform
  function automatic logic [7:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0, 1:    return 8'h00;
      2:       return 8'h01;
      3:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: one transaction per handshake, random idle bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    bit handed;
    bit next_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_idle = 0;
    end else begin
      handed = in_ch.valid && in_ch.ready;
      if (handed) begin
        awaited_results.push_back(predict_result(cur_req));
        sent_count++;
      end
      next_valid = in_ch.valid && !handed;
      if (!next_valid) begin
        if (send_idle > 0) begin
          send_idle--;
        end else if (!late_phase && $urandom_range(0, 7) == 0) begin
          // start an idle burst of random length, counted down in send_idle
          send_idle = $urandom_range(0, 9);
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold && (handed || awaited_results.size() != 0))) begin
          cur_req = pending_reqs.pop_front();
          if (cur_req.hold) begin
            drain_waits++;
          end
          in_ch.opcode    <= cur_req.op;
          in_ch.operand_a <= cur_req.a;
          in_ch.operand_b <= cur_req.b;
          next_valid = 1'b1;
        end
      end
      in_ch.valid <= next_valid;
      // the tail of the run goes without idling on either side
      late_phase <= (pending_reqs.size() < QUIET_TAIL);
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares each result transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    field_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("result %02h zero %0b with nothing outstanding",
                                  out_ch.result_value, out_ch.zero_operand));
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.result_value !== want.value) begin
            flag_mismatch($sformatf("%s a=%02h b=%02h: result %02h, want %02h",
                                    want.op.name(), want.a, want.b,
                                    out_ch.result_value, want.value));
          end
          if (out_ch.zero_operand !== want.zflag) begin
            flag_mismatch($sformatf("%s a=%02h b=%02h: zero flag %0b, want %0b",
                                    want.op.name(), want.a, want.b,
                                    out_ch.zero_operand, want.zflag));
          end
          checked_count++;
          op_seen[want.op]++;
          if (want.zflag) begin
            zero_flag_count++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ch.ready <= 1'b0;
      end else if (!late_phase && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 9);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_MUL;
    in_ch.operand_a = 8'h00;
    in_ch.operand_b = 8'h00;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;

    // multiply: zeros, all-ones, identity, reductions on the top bit
    add_request(OP_MUL, 8'h00, 8'h00, 1'b0);
    add_request(OP_MUL, 8'hFF, 8'hFF, 1'b0);
    add_request(OP_MUL, 8'h00, 8'hA5, 1'b0);
    add_request(OP_MUL, 8'h01, 8'h5C, 1'b0);
    add_request(OP_MUL, 8'h80, 8'h02, 1'b0);
    add_request(OP_MUL, 8'h80, 8'h80, 1'b0);
    // inverse: zero operand raises the flag, one is its own inverse;
    // operand_b carries junk that must be ignored
    add_request(OP_INV, 8'h00, 8'hFF, 1'b0);
    add_request(OP_INV, 8'h01, 8'h00, 1'b0);
    add_request(OP_INV, 8'h02, 8'h5A, 1'b0);
    add_request(OP_INV, 8'hFF, 8'hFF, 1'b0);
    // power of alpha: exponent 255 wraps to 1
    add_request(OP_POW, 8'h00, 8'hFF, 1'b0);
    add_request(OP_POW, 8'h01, 8'h00, 1'b0);
    add_request(OP_POW, 8'h08, 8'hC3, 1'b0);
    add_request(OP_POW, 8'hFE, 8'h00, 1'b0);
    add_request(OP_POW, 8'hFF, 8'hFF, 1'b0);
    // logarithm: zero raises the flag
    add_request(OP_LOG, 8'h00, 8'h3C, 1'b0);
    add_request(OP_LOG, 8'h01, 8'hFF, 1'b0);
    add_request(OP_LOG, 8'h02, 8'h00, 1'b0);
    add_request(OP_LOG, 8'h71, 8'h81, 1'b0);
    add_request(OP_LOG, 8'hFF, 8'hFF, 1'b0);

    // random mix; every 250th one waits for the pipeline to run dry first
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_request(opcode_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                  (i % 250) == 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent_count == total_reqs);
    wait (awaited_results.size() == 0);
    // two-stage pipeline: the extra wait catches any stray result
    repeat (8) @(posedge clk);

    $display("covered %0d transactions: %0d multiply, %0d inverse, %0d power, %0d log",
             checked_count, op_seen[OP_MUL], op_seen[OP_INV], op_seen[OP_POW],
             op_seen[OP_LOG]);
    $display("%0d zero-operand flags, %0d sends held for an empty pipeline, %0d mismatches",
             zero_flag_count, drain_waits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
